// ===== design/assert_macros.svh =====
// Assertion helpers, included by tgd_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is low.
`define TGD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("touch gesture detector: assertion failed");

// Concurrent check that a condition never occurs.
`define TGD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `TGD_ASSERT(lbl, clk, rstn, !(cond))

`endif

// ===== design/tgd_pkg.sv =====
`default_nettype none

package tgd_pkg;

  // Width of each configuration register.
  localparam int unsigned CfgWidth = 16;

  // APB port geometry: three 32-bit registers at byte addresses 0, 4 and 8.
  localparam int unsigned ApbAddrWidth = 4;
  localparam int unsigned ApbDataWidth = 32;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_NOISE_WINDOW   = 2'd0,
    REG_DOUBLE_TAP_GAP = 2'd1,
    REG_HOLD_TIME      = 2'd2
  } reg_idx_e;

  // Register reset values.
  localparam logic [CfgWidth-1:0] NoiseWindowReset  = 16'd40;
  localparam logic [CfgWidth-1:0] DoubleTapGapReset = 16'd100;
  localparam logic [CfgWidth-1:0] HoldTimeReset     = 16'd1000;

  // Gesture machine states, as reported on machine_state.
  typedef enum logic [2:0] {
    ST_INIT          = 3'd0,
    ST_UP            = 3'd1,
    ST_DOWN          = 3'd2,
    ST_POST_HOLD     = 3'd3,
    ST_TAPPED        = 3'd4,
    ST_DOUBLE_TAPPED = 3'd5
  } gstate_e;

  // Events, as reported on gesture_event.
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_TAP        = 3'd1,
    EV_DOUBLE_TAP = 3'd2,
    EV_HOLD       = 3'd3,
    EV_TAP_HOLD   = 3'd4
  } gevent_e;

  // Configuration as seen by the gesture core.
  typedef struct packed {
    logic [CfgWidth-1:0] noise_window;
    logic [CfgWidth-1:0] double_tap_gap;
    logic [CfgWidth-1:0] hold_time;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/tgd_cfg_regs.sv =====
`default_nettype none

module tgd_cfg_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [tgd_pkg::ApbAddrWidth-1:0]     paddr,
  input  wire logic [tgd_pkg::ApbDataWidth-1:0]     pwdata,
  output logic      [tgd_pkg::ApbDataWidth-1:0]     prdata,
  output logic                                      pready,
  output tgd_pkg::cfg_t                             cfg_o
);

  tgd_pkg::cfg_t cfg_q;
  logic [1:0]    reg_idx;
  logic          wr_en;

  // No wait states.
  assign pready = 1'b1;

  // Word index of the addressed register.
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register file; a write to an unused address is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_window   <= tgd_pkg::NoiseWindowReset;
      cfg_q.double_tap_gap <= tgd_pkg::DoubleTapGapReset;
      cfg_q.hold_time      <= tgd_pkg::HoldTimeReset;
    end else if (wr_en) begin
      case (reg_idx)
        tgd_pkg::REG_NOISE_WINDOW: begin
          cfg_q.noise_window <= pwdata[tgd_pkg::CfgWidth-1:0];
        end
        tgd_pkg::REG_DOUBLE_TAP_GAP: begin
          cfg_q.double_tap_gap <= pwdata[tgd_pkg::CfgWidth-1:0];
        end
        tgd_pkg::REG_HOLD_TIME: begin
          cfg_q.hold_time <= pwdata[tgd_pkg::CfgWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      tgd_pkg::REG_NOISE_WINDOW: begin
        prdata = tgd_pkg::ApbDataWidth'(cfg_q.noise_window);
      end
      tgd_pkg::REG_DOUBLE_TAP_GAP: begin
        prdata = tgd_pkg::ApbDataWidth'(cfg_q.double_tap_gap);
      end
      tgd_pkg::REG_HOLD_TIME: begin
        prdata = tgd_pkg::ApbDataWidth'(cfg_q.hold_time);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/tgd_core.sv =====
`default_nettype none

`include "assert_macros.svh"

module tgd_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          touch_i,
  input  wire tgd_pkg::cfg_t cfg_i,
  output tgd_pkg::gevent_e   event_o,
  output tgd_pkg::gstate_e   state_o
);

  // Compares are done at the wider of the counter and register widths.
  localparam int unsigned CmpWidth =
    (COUNT_WIDTH > tgd_pkg::CfgWidth) ? COUNT_WIDTH : tgd_pkg::CfgWidth;

  tgd_pkg::gstate_e       state_q, state_d;
  tgd_pkg::gevent_e       event_d;
  tgd_pkg::gstate_e       state_out_q;
  tgd_pkg::gevent_e       event_out_q;
  logic [COUNT_WIDTH-1:0] since_press_q, since_press_d;
  logic [COUNT_WIDTH-1:0] since_release_q, since_release_d;
  logic                   last_touch_q, last_touch_d;

  logic [COUNT_WIDTH-1:0] press_adv, release_adv;
  logic [CmpWidth-1:0]    press_x, release_x;
  logic [CmpWidth-1:0]    noise_x, gap_x, hold_x;
  logic                   noise, held_long, gap_done, in_init;

  // Saturating advance of both edge counters.
  assign press_adv   = (since_press_q == {COUNT_WIDTH{1'b1}}) ? since_press_q
                                                                : since_press_q + 1'b1;
  assign release_adv = (since_release_q == {COUNT_WIDTH{1'b1}}) ? since_release_q
                                                                  : since_release_q + 1'b1;

  // Timing compares against the configured windows.
  assign press_x   = CmpWidth'(press_adv);
  assign release_x = CmpWidth'(release_adv);
  assign noise_x   = CmpWidth'(cfg_i.noise_window);
  assign gap_x     = CmpWidth'(cfg_i.double_tap_gap);
  assign hold_x    = CmpWidth'(cfg_i.hold_time);

  assign noise     = touch_i ? (release_x < noise_x) : (press_x < noise_x);
  assign held_long = press_x > hold_x;
  assign gap_done  = release_x > gap_x;
  assign in_init   = (state_q == tgd_pkg::ST_INIT);

  // Next state. After init, a noisy sample leaves the state alone.
  always_comb begin
    state_d = state_q;
    if (in_init) begin
      state_d = touch_i ? tgd_pkg::ST_DOWN : tgd_pkg::ST_UP;
    end else if (!noise) begin
      case (state_q)
        tgd_pkg::ST_UP: begin
          if (touch_i) state_d = tgd_pkg::ST_DOWN;
        end
        tgd_pkg::ST_DOWN: begin
          if (!touch_i) begin
            state_d = tgd_pkg::ST_TAPPED;
          end else if (held_long) begin
            state_d = tgd_pkg::ST_POST_HOLD;
          end
        end
        tgd_pkg::ST_POST_HOLD: begin
          if (!touch_i) state_d = tgd_pkg::ST_UP;
        end
        tgd_pkg::ST_TAPPED: begin
          if (touch_i) begin
            state_d = tgd_pkg::ST_DOUBLE_TAPPED;
          end else if (gap_done) begin
            state_d = tgd_pkg::ST_UP;
          end
        end
        tgd_pkg::ST_DOUBLE_TAPPED: begin
          if (touch_i) begin
            if (held_long) state_d = tgd_pkg::ST_POST_HOLD;
          end else if (gap_done) begin
            state_d = tgd_pkg::ST_UP;
          end
        end
        default: begin
          state_d = tgd_pkg::ST_UP;
        end
      endcase
    end
  end

  // Event reported for this sample.
  always_comb begin
    event_d = tgd_pkg::EV_NONE;
    if (!in_init && !noise) begin
      case (state_q)
        tgd_pkg::ST_DOWN: begin
          if (touch_i && held_long) event_d = tgd_pkg::EV_HOLD;
        end
        tgd_pkg::ST_TAPPED: begin
          if (!touch_i && gap_done) event_d = tgd_pkg::EV_TAP;
        end
        tgd_pkg::ST_DOUBLE_TAPPED: begin
          if (touch_i && held_long) begin
            event_d = tgd_pkg::EV_TAP_HOLD;
          end else if (!touch_i && gap_done) begin
            event_d = tgd_pkg::EV_DOUBLE_TAP;
          end
        end
        default: begin
          event_d = tgd_pkg::EV_NONE;
        end
      endcase
    end
  end

  // Edge bookkeeping. The first sample records no edge.
  always_comb begin
    since_press_d   = press_adv;
    since_release_d = release_adv;
    last_touch_d    = last_touch_q;
    if (!in_init) begin
      if (touch_i && !last_touch_q) begin
        since_press_d = '0;
        last_touch_d  = 1'b1;
      end else if (!touch_i && last_touch_q) begin
        since_release_d = '0;
        last_touch_d    = 1'b0;
      end
    end
  end

  // Gesture state, advanced once per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= tgd_pkg::ST_INIT;
      since_press_q   <= '0;
      since_release_q <= '0;
      last_touch_q    <= 1'b0;
    end else if (step_i) begin
      state_q         <= state_d;
      since_press_q   <= since_press_d;
      since_release_q <= since_release_d;
      last_touch_q    <= last_touch_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      state_out_q <= state_d;
      event_out_q <= event_d;
    end
  end

  assign event_o = event_out_q;
  assign state_o = state_out_q;

  // The first sample leaves init for up or down.
  `TGD_ASSERT(a_init_exit, clk_i, rst_ni,
    step_i && in_init |=> state_q == tgd_pkg::ST_UP || state_q == tgd_pkg::ST_DOWN)

  // A final event always settles the machine in up or post hold.
  `TGD_ASSERT(a_event_settles, clk_i, rst_ni,
    step_i && event_d != tgd_pkg::EV_NONE |->
      state_d == tgd_pkg::ST_UP || state_d == tgd_pkg::ST_POST_HOLD)

  // Without a transaction the gesture state and counters hold.
  `TGD_ASSERT(a_idle_holds, clk_i, rst_ni,
    !step_i |=> $stable(state_q) && $stable(since_press_q) && $stable(since_release_q))

  // A press edge after init restarts the press counter.
  `TGD_ASSERT(a_press_clears, clk_i, rst_ni,
    step_i && !in_init && touch_i && !last_touch_q |=> since_press_q == '0 && last_touch_q)

endmodule

`default_nettype wire

// ===== design/touch_gesture_detector_top.sv =====
`default_nettype none

// Tap, double tap, hold and tap-hold detector for one touch pad. Each input
// transaction carries one touch sample (one per millisecond tick); each sample
// yields exactly one output transaction with the event it caused and the
// machine state after it. A new sample can be taken every clock cycle unless
// in_stall_o is high. Each sample passes through the input register and then
// the result register; the input register can take the next sample in while a
// result still waits. The three timing windows are set over the APB
// port (noise_window at 0x0, double_tap_gap at 0x4, hold_time at 0x8) and
// should only be written while no transaction is in flight.
module touch_gesture_detector_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Sample channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                touch_i,
  // Result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [2:0]                          gesture_event_o,
  output logic      [2:0]                          machine_state_o,
  // Configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tgd_pkg::ApbAddrWidth-1:0]    paddr,
  input  wire logic [tgd_pkg::ApbDataWidth-1:0]    pwdata,
  output logic      [tgd_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                     pready
);

  tgd_pkg::cfg_t    cfg;
  tgd_pkg::gevent_e core_event;
  tgd_pkg::gstate_e core_state;

  logic in_valid_q;
  logic in_touch_q;
  logic out_valid_q;
  logic out_free, step, in_accept;

  // Handshake: the result register frees when empty or being taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register valid and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_touch_q <= touch_i;
    end
  end

  tgd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tgd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .touch_i (in_touch_q),
    .cfg_i   (cfg),
    .event_o (core_event),
    .state_o (core_state)
  );

  assign out_valid_o     = out_valid_q;
  assign gesture_event_o = core_event;
  assign machine_state_o = core_state;

endmodule

`default_nettype wire
